FILE: rtl/urf_pkg.sv
package urf_pkg;

  localparam int FIFO_DEPTH_DEF = 16;

  // Item operations.
  localparam logic [1:0] OP_RX    = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_PERIPH_ID = 1'b0;
  localparam logic CFG_CELL_ID   = 1'b1;

  // Register byte offsets.
  localparam logic [11:0] ADDR_DR    = 12'h000;
  localparam logic [11:0] ADDR_RSR   = 12'h004;
  localparam logic [11:0] ADDR_FR    = 12'h018;
  localparam logic [11:0] ADDR_ILPR  = 12'h020;
  localparam logic [11:0] ADDR_IBRD  = 12'h024;
  localparam logic [11:0] ADDR_FBRD  = 12'h028;
  localparam logic [11:0] ADDR_LCR   = 12'h02C;
  localparam logic [11:0] ADDR_CR    = 12'h030;
  localparam logic [11:0] ADDR_IFLS  = 12'h034;
  localparam logic [11:0] ADDR_IMSC  = 12'h038;
  localparam logic [11:0] ADDR_RIS   = 12'h03C;
  localparam logic [11:0] ADDR_MIS   = 12'h040;
  localparam logic [11:0] ADDR_ICR   = 12'h044;
  localparam logic [11:0] ADDR_DMACR = 12'h048;
  localparam logic [7:0]  ID_PERIPH_PAGE = 8'hFE;
  localparam logic [7:0]  ID_CELL_PAGE   = 8'hFF;

  // Bit positions.
  localparam int LCR_FEN_BIT = 4;
  localparam int CR_UARTEN_BIT = 0;
  localparam int CR_TXE_BIT = 8;
  localparam int CR_RXE_BIT = 9;
  localparam int INT_RX_BIT = 4;
  localparam int INT_TX_BIT = 5;
  localparam int INT_W = 11;

  localparam logic [31:0] PERIPH_ID_RESET = 32'h0034_1011;
  localparam logic [31:0] CELL_ID_RESET   = 32'hB105_F00D;
  localparam logic [15:0] CR_RESET        = 16'h0300;

  typedef struct packed {
    logic [1:0]  operation;
    logic [11:0] address;
    logic [15:0] write_data;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        irq;
  } out_item_t;

  typedef struct packed {
    logic        we;
    logic        index;
    logic [31:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic       push;
    logic       pop;
    logic       fifo_en;
    logic [7:0] push_byte;
  } fifo_ctrl_t;

  typedef struct packed {
    logic       empty;
    logic       single;
    logic       full;
    logic [7:0] head_byte;
  } fifo_stat_t;

endpackage

FILE: rtl/urf_ifs.sv
interface urf_req_if;
  logic valid;
  logic ready;
  urf_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface urf_rsp_if;
  logic valid;
  logic ready;
  urf_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/uart_register_file_with_rx_fifo.sv
// Channel  Role    Beat contents
// -------  ------  -------------------------------------------------------
// req      sink    operation, address, write_data, rx_byte
// rsp      source  read_data, tx_valid, tx_byte, irq
// cfg_*    write   cfg_index selects peripheral id (0) or cell id (1)
//
// One item is accepted every cycle while rsp is not stalled. Its result is
// loaded into the result register as the item leaves the stage.
// The rate is set by the single state update per cycle in the stage, with
// the RX byte at the FIFO head fetched ahead from the byte array.
// Reset is synchronous and clears all control state; the byte array is not
// cleared, since a byte is read only after it has been written.
// A stalled rsp holds the result register; the stage keeps one more item,
// and req.ready drops only while both are full and rsp is stalled.
module uart_register_file_with_rx_fifo #(
  parameter int FIFO_DEPTH = urf_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  urf_req_if.sink     req,
  urf_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);
  import urf_pkg::*;

  // Stage register: holds the item being applied to the register state.
  logic       s_valid;
  in_item_t   s_item;

  // Result register: holds the finished result until rsp takes it.
  logic       o_valid;
  out_item_t  o_item;

  logic       adv;
  out_item_t  result;
  cfg_wr_t    cfg;
  fifo_ctrl_t fctrl;
  fifo_stat_t fstat;

  // The staged item commits its state update at the same edge that loads
  // its result, so the state seen by the next item is always current.
  assign adv       = s_valid && (!o_valid || rsp.ready);
  assign req.ready = !s_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (req.ready) begin
      s_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      s_item <= req.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_item <= result;
    end
  end

  assign rsp.valid = o_valid;
  assign rsp.data  = o_item;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // Register decode, read mux and interrupt logic.
  urf_core u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (adv),
    .item   (s_item),
    .cfg    (cfg),
    .fstat  (fstat),
    .fctrl  (fctrl),
    .result (result)
  );

  // Receive FIFO with head prefetch.
  urf_rx_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_rx_fifo (
    .clk  (clk),
    .rst  (rst),
    .ctrl (fctrl),
    .stat (fstat)
  );

`ifndef ASSERT_OFF
  // With both registers full and the output stalled, no new beat may enter.
  a_stall_blocks_req: assert property (@(posedge clk) disable iff (rst)
    (s_valid && o_valid && !rsp.ready) |-> !req.ready)
    else $error("req accepted while the pipeline is full and stalled");

  // A committed item always leaves a result behind.
  a_adv_loads_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> o_valid)
    else $error("staged item committed without a result");

  // A transmitted byte comes from a write, never from a read.
  a_tx_no_rdata: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_item.tx_valid) |-> (o_item.read_data == 16'h0000))
    else $error("result carries read data and a transmit byte at once");

  // The FIFO never pops and pushes for the same item.
  a_fifo_one_op: assert property (@(posedge clk) disable iff (rst)
    !(fctrl.push && fctrl.pop))
    else $error("FIFO pushed and popped for one item");
`endif

endmodule

FILE: rtl/urf_rx_fifo.sv
module urf_rx_fifo #(
  parameter int FIFO_DEPTH = urf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  urf_pkg::fifo_ctrl_t ctrl,
  output urf_pkg::fifo_stat_t stat
);
  import urf_pkg::*;

  localparam int IW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int SW = CW + 1;

  logic [7:0]    mem [FIFO_DEPTH];
  logic [IW-1:0] head;
  logic [IW-1:0] head_next;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [SW-1:0] tail_sum;
  logic [IW-1:0] tail;
  logic [7:0]    head_data;
  logic          full;
  logic          do_push;
  logic          do_pop;

  assign full = ctrl.fifo_en ? (count >= CW'(FIFO_DEPTH)) : (count != '0);
  assign do_push = ctrl.push && !full;
  assign do_pop  = ctrl.pop && (count != '0);

  // The head stays below the depth and the count never exceeds it, so one conditional subtract wraps the sum.
  always_comb begin
    tail_sum = SW'(head) + SW'(count);
    if (tail_sum >= SW'(FIFO_DEPTH)) begin
      tail_sum = tail_sum - SW'(FIFO_DEPTH);
    end
    tail = tail_sum[IW-1:0];
  end

  always_comb begin
    head_next  = head;
    count_next = count;
    if (do_pop) begin
      head_next  = (head == IW'(FIFO_DEPTH - 1)) ? '0 : head + 1'b1;
      count_next = count - 1'b1;
    end else if (do_push) begin
      count_next = count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else begin
      head  <= head_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= ctrl.push_byte;
    end
  end

  // The byte at the head is fetched ahead into a register from the next head
  // index; a push into an empty FIFO lands at the head and is forwarded around the array.
  always_ff @(posedge clk) begin
    if (do_push && (tail == head_next)) begin
      head_data <= ctrl.push_byte;
    end else begin
      head_data <= mem[head_next];
    end
  end

  assign stat.empty     = (count == '0);
  assign stat.single    = (count == CW'(1));
  assign stat.full      = full;
  assign stat.head_byte = head_data;

endmodule

FILE: rtl/urf_core.sv
module urf_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  urf_pkg::in_item_t   item,
  input  urf_pkg::cfg_wr_t    cfg,
  input  urf_pkg::fifo_stat_t fstat,
  output urf_pkg::fifo_ctrl_t fctrl,
  output urf_pkg::out_item_t  result
);
  import urf_pkg::*;

  logic [31:0]      periph_id;
  logic [31:0]      cell_id;
  logic [7:0]       line_control;
  logic [15:0]      control_word;
  logic [INT_W-1:0] int_mask;
  logic             tx_raw;
  logic [15:0]      baud_integer;
  logic [5:0]       baud_fraction;
  logic [5:0]       level_select;
  logic [7:0]       irda_divisor;
  logic [15:0]      dma_control;

  logic [INT_W-1:0] int_mask_next;
  logic             tx_raw_next;
  logic [INT_W-1:0] raw_now;
  logic [INT_W-1:0] raw_after;
  logic             rx_after;
  logic             is_rx;
  logic             is_read;
  logic             is_write;
  logic             aligned;
  logic             rx_enabled;
  logic             dr_read;
  logic             tx_send;
  logic [15:0]      rdata;
  logic [1:0]       id_sel;

  assign is_rx    = (item.operation == OP_RX);
  assign is_read  = (item.operation == OP_READ);
  assign is_write = (item.operation == OP_WRITE);
  assign aligned  = (item.address[1:0] == 2'b00);
  assign id_sel   = item.address[3:2];

  assign rx_enabled = control_word[CR_UARTEN_BIT] || control_word[CR_RXE_BIT];
  assign dr_read    = is_read && (item.address == ADDR_DR);
  assign tx_send    = is_write && (item.address == ADDR_DR) && control_word[CR_TXE_BIT];

  always_comb begin
    raw_now = '0;
    raw_now[INT_RX_BIT] = !fstat.empty;
    raw_now[INT_TX_BIT] = tx_raw;
  end

  always_comb begin
    rdata = '0;
    if (!aligned) begin
      rdata = '0;
    end else if (item.address[11:4] == ID_PERIPH_PAGE) begin
      rdata = {8'h00, periph_id[8*id_sel +: 8]};
    end else if (item.address[11:4] == ID_CELL_PAGE) begin
      rdata = {8'h00, cell_id[8*id_sel +: 8]};
    end else begin
      unique case (item.address)
        ADDR_DR:    rdata = fstat.empty ? 16'h0000 : {8'h00, fstat.head_byte};
        ADDR_FR:    rdata = {8'h00, 1'b1, fstat.full, 1'b0, fstat.empty, 4'h0};
        ADDR_ILPR:  rdata = {8'h00, irda_divisor};
        ADDR_IBRD:  rdata = baud_integer;
        ADDR_FBRD:  rdata = {10'h000, baud_fraction};
        ADDR_LCR:   rdata = {8'h00, line_control};
        ADDR_CR:    rdata = control_word;
        ADDR_IFLS:  rdata = {10'h000, level_select};
        ADDR_IMSC:  rdata = {5'h00, int_mask};
        ADDR_RIS:   rdata = {5'h00, raw_now};
        ADDR_MIS:   rdata = {5'h00, raw_now & int_mask};
        ADDR_DMACR: rdata = dma_control;
        default:    rdata = '0;
      endcase
    end
  end

  always_comb begin
    int_mask_next = int_mask;
    tx_raw_next   = tx_raw;
    if (is_write && (item.address == ADDR_IMSC)) begin
      int_mask_next = item.write_data[INT_W-1:0];
    end
    if (tx_send) begin
      tx_raw_next = 1'b1;
    end else if (is_write && (item.address == ADDR_ICR) && item.write_data[INT_TX_BIT]) begin
      tx_raw_next = 1'b0;
    end
  end

  // RX status tracks occupancy after this item: a receive with the receiver enabled
  // leaves the FIFO occupied whether or not the byte fit, and a pop of the last byte empties it.
  assign rx_after = (is_rx && rx_enabled) || (!fstat.empty && !(dr_read && fstat.single));

  always_comb begin
    raw_after = '0;
    raw_after[INT_RX_BIT] = rx_after;
    raw_after[INT_TX_BIT] = tx_raw_next;
  end

  assign fctrl.push      = fire && is_rx && rx_enabled;
  assign fctrl.pop       = fire && dr_read;
  assign fctrl.fifo_en   = line_control[LCR_FEN_BIT];
  assign fctrl.push_byte = item.rx_byte;

  assign result.read_data = is_read ? rdata : 16'h0000;
  assign result.tx_valid  = tx_send;
  assign result.tx_byte   = tx_send ? item.write_data[7:0] : 8'h00;
  assign result.irq       = |(raw_after & int_mask_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      periph_id     <= PERIPH_ID_RESET;
      cell_id       <= CELL_ID_RESET;
      line_control  <= '0;
      control_word  <= CR_RESET;
      int_mask      <= '0;
      tx_raw        <= 1'b0;
      baud_integer  <= '0;
      baud_fraction <= '0;
      level_select  <= '0;
      irda_divisor  <= '0;
      dma_control   <= '0;
    end else begin
      if (cfg.we) begin
        unique case (cfg.index)
          CFG_PERIPH_ID: periph_id <= cfg.data;
          CFG_CELL_ID:   cell_id   <= cfg.data;
          default:       periph_id <= periph_id;
        endcase
      end
      if (fire) begin
        int_mask <= int_mask_next;
        tx_raw   <= tx_raw_next;
        if (is_write) begin
          unique case (item.address)
            ADDR_ILPR:  irda_divisor  <= item.write_data[7:0];
            ADDR_IBRD:  baud_integer  <= item.write_data;
            ADDR_FBRD:  baud_fraction <= item.write_data[5:0];
            ADDR_LCR:   line_control  <= item.write_data[7:0];
            ADDR_CR:    control_word  <= item.write_data;
            ADDR_IFLS:  level_select  <= item.write_data[5:0];
            ADDR_DMACR: dma_control   <= item.write_data;
            default:    dma_control   <= dma_control;
          endcase
        end
      end
    end
  end

endmodule

FILE: tb/tb_uart_register_file_with_rx_fifo.sv
module tb_uart_register_file_with_rx_fifo;
  import urf_pkg::*;

  localparam int FIFO_DEPTH = FIFO_DEPTH_DEF;

  // The operation value that the block leaves unused.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Flag register bits.
  localparam logic [7:0] FLAG_TXFE = 8'h80;
  localparam logic [7:0] FLAG_RXFF = 8'h40;
  localparam logic [7:0] FLAG_RXFE = 8'h10;

  // The random traffic runs in stretches that either fill the receive FIFO,
  // drain it, or touch the whole register map.
  typedef enum int unsigned {MIX_FILL, MIX_DRAIN, MIX_ANY} traffic_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_data;

  urf_req_if req_if ();
  urf_rsp_if rsp_if ();

  uart_register_file_with_rx_fifo #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_if),
    .rsp       (rsp_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // The run is cut off here if the handshakes ever stop moving.
  initial begin
    #1_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Percent chances, per cycle, that the request side holds back and that
  // the response side stalls.
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;

  int unsigned n_beats = 0;
  int unsigned n_checked = 0;
  int unsigned n_errors = 0;
  int unsigned n_tx_bytes = 0;
  int unsigned n_popped = 0;
  int unsigned n_dropped = 0;

  // Responses still owed by the block, oldest first.
  out_item_t pending_responses[$];

  // Our own copy of the register file and the receive FIFO.
  logic [7:0]  rx_bytes [FIFO_DEPTH];
  int unsigned rx_level;
  int unsigned rx_rd_ptr;
  logic [7:0]  lcr;
  logic [15:0] cr;
  logic [INT_W-1:0] imsc;
  logic [INT_W-1:0] ris;
  logic [15:0] ibrd;
  logic [5:0]  fbrd;
  logic [5:0]  ifls;
  logic [7:0]  ilpr;
  logic [15:0] dmacr;
  logic [31:0] periph_id;
  logic [31:0] cell_id;

  function automatic void reset_uart_model();
    rx_level  = 0;
    rx_rd_ptr = 0;
    lcr       = '0;
    cr        = CR_RESET;
    imsc      = '0;
    ris       = '0;
    ibrd      = '0;
    fbrd      = '0;
    ifls      = '0;
    ilpr      = '0;
    dmacr     = '0;
    periph_id = PERIPH_ID_RESET;
    cell_id   = CELL_ID_RESET;
  endfunction

  // With the FIFO-enable bit clear the FIFO acts as a single holding byte.
  function automatic int unsigned active_depth();
    return lcr[LCR_FEN_BIT] ? FIFO_DEPTH : 1;
  endfunction

  // The RX raw interrupt simply mirrors "FIFO not empty".
  function automatic void update_rx_status();
    ris[INT_RX_BIT] = (rx_level != 0);
  endfunction

  function automatic logic [15:0] read_register(logic [11:0] a);
    logic [15:0] v;
    v = '0;
    if (a[1:0] != 2'b00) return '0;
    if (a[11:4] == ID_PERIPH_PAGE) return {8'h00, periph_id[{a[3:2], 3'b000} +: 8]};
    if (a[11:4] == ID_CELL_PAGE) return {8'h00, cell_id[{a[3:2], 3'b000} +: 8]};
    case (a)
      ADDR_DR: begin
        // Reading an empty FIFO returns zero and changes nothing.
        if (rx_level != 0) begin
          v = {8'h00, rx_bytes[rx_rd_ptr]};
          rx_rd_ptr = (rx_rd_ptr + 1) % FIFO_DEPTH;
          rx_level--;
          n_popped++;
        end
        update_rx_status();
      end
      ADDR_FR: begin
        v[7:0] = FLAG_TXFE;
        if (rx_level == 0) v[7:0] = v[7:0] | FLAG_RXFE;
        if (rx_level >= active_depth()) v[7:0] = v[7:0] | FLAG_RXFF;
      end
      ADDR_ILPR:  v = {8'h00, ilpr};
      ADDR_IBRD:  v = ibrd;
      ADDR_FBRD:  v = {10'h000, fbrd};
      ADDR_LCR:   v = {8'h00, lcr};
      ADDR_CR:    v = cr;
      ADDR_IFLS:  v = {10'h000, ifls};
      ADDR_IMSC:  v = {5'h00, imsc};
      ADDR_RIS:   v = {5'h00, ris};
      ADDR_MIS:   v = {5'h00, ris & imsc};
      ADDR_DMACR: v = dmacr;
      default:    v = '0;
    endcase
    return v;
  endfunction

  // Returns 1 when the write sends a byte to the line.
  function automatic logic write_register(logic [11:0] a, logic [15:0] d);
    if (a[1:0] != 2'b00) return 1'b0;
    case (a)
      ADDR_DR: begin
        if (!cr[CR_TXE_BIT]) return 1'b0;
        ris[INT_TX_BIT] = 1'b1;
        return 1'b1;
      end
      ADDR_ILPR:  ilpr  = d[7:0];
      ADDR_IBRD:  ibrd  = d;
      ADDR_FBRD:  fbrd  = d[5:0];
      ADDR_LCR:   lcr   = d[7:0];
      ADDR_CR:    cr    = d;
      ADDR_IFLS:  ifls  = d[5:0];
      ADDR_IMSC:  imsc  = d[INT_W-1:0];
      ADDR_ICR: begin
        ris = ris & ~d[INT_W-1:0];
        update_rx_status();
      end
      ADDR_DMACR: dmacr = d;
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Advances our register file by one accepted beat and returns the
  // response the block must give for it.
  function automatic out_item_t uart_response(in_item_t it);
    out_item_t r;
    r = '0;
    case (it.operation)
      OP_RX: begin
        // The receiver listens when either UARTEN or RXE is set.
        if (cr[CR_UARTEN_BIT] || cr[CR_RXE_BIT]) begin
          if (rx_level < active_depth()) begin
            rx_bytes[(rx_rd_ptr + rx_level) % FIFO_DEPTH] = it.rx_byte;
            rx_level++;
          end else begin
            n_dropped++;
          end
          update_rx_status();
        end
      end
      OP_READ: r.read_data = read_register(it.address);
      OP_WRITE: begin
        if (write_register(it.address, it.write_data)) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = it.write_data[7:0];
          n_tx_bytes++;
        end
      end
      default: ;
    endcase
    r.irq = |(ris & imsc);
    return r;
  endfunction

  function automatic void check_response(out_item_t got);
    out_item_t want;
    if (pending_responses.size() == 0) begin
      $error("response beat with nothing outstanding: read_data %h", got.read_data);
      n_errors++;
      return;
    end
    want = pending_responses.pop_front();
    n_checked++;
    if (got.read_data !== want.read_data) begin
      $error("read_data: expected %h, actual %h", want.read_data, got.read_data);
      n_errors++;
    end
    if (got.tx_valid !== want.tx_valid) begin
      $error("tx_valid: expected %b, actual %b", want.tx_valid, got.tx_valid);
      n_errors++;
    end
    if (got.tx_byte !== want.tx_byte) begin
      $error("tx_byte: expected %h, actual %h", want.tx_byte, got.tx_byte);
      n_errors++;
    end
    if (got.irq !== want.irq) begin
      $error("irq: expected %b, actual %b", want.irq, got.irq);
      n_errors++;
    end
  endfunction

  // Response side: the handshake is judged on the values that stood before
  // the edge, and ready is redrawn after every edge so stalls land on
  // every pipeline phase.
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready) check_response(rsp_if.data);
      rsp_if.ready <= !rst && ($urandom_range(99) >= stall_pct);
    end
  end

  // Presents one request beat, possibly after some idle cycles, and holds
  // it until the block takes it. The expectation is formed at acceptance so
  // the model sees beats in exactly the order the block does. Valid is left
  // high so that back-to-back beats need no extra assignment.
  task automatic send_beat(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    do @(posedge clk); while (!req_if.ready);
    pending_responses.push_back(uart_response(it));
    n_beats++;
  endtask

  // Stops sending and lets every outstanding response come back.
  task automatic wait_idle();
    req_if.valid <= 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic in_item_t beat_of(logic [1:0] op, logic [11:0] a, logic [15:0] d,
                                       logic [7:0] b);
    in_item_t it;
    it.operation  = op;
    it.address    = a;
    it.write_data = d;
    it.rx_byte    = b;
    return it;
  endfunction

  task automatic do_read(logic [11:0] a);
    send_beat(beat_of(OP_READ, a, '0, '0));
  endtask

  task automatic do_write(logic [11:0] a, logic [15:0] d);
    send_beat(beat_of(OP_WRITE, a, d, '0));
  endtask

  task automatic do_receive(logic [7:0] b);
    send_beat(beat_of(OP_RX, '0, '0, b));
  endtask

  // The ID registers are only written while the block is idle.
  task automatic write_id_register(logic idx, logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    if (idx == CFG_PERIPH_ID) periph_id = v;
    else cell_id = v;
  endtask

  // A single holding byte: the second byte is dropped, and reading the
  // emptied data register gives zero.
  task automatic test_receive_single();
    do_write(ADDR_LCR, 16'h0000);
    do_receive(8'hFF);
    do_receive(8'h00);
    do_read(ADDR_FR);
    do_read(ADDR_DR);
    do_read(ADDR_DR);
  endtask

  // A sent byte raises TX in the raw status, the mask routes it to irq, and
  // the clear register takes it away again.
  task automatic test_transmit_and_interrupts();
    do_write(ADDR_IMSC, 16'hFFFF);
    do_write(ADDR_DR, 16'hFFFF);
    do_read(ADDR_RIS);
    do_write(ADDR_ICR, 16'hFFFF);
    do_read(ADDR_MIS);
  endtask

  // Receiver and transmitter switched off, then UARTEN alone, which lets
  // the receiver work but keeps the transmitter off.
  task automatic test_disabled_paths();
    do_write(ADDR_CR, 16'h0000);
    do_receive(8'h5A);
    do_write(ADDR_DR, 16'h1234);
    do_write(ADDR_CR, 16'h0001);
    do_receive(8'hA5);
    do_write(ADDR_DR, 16'h00C3);
    do_read(ADDR_DR);
    do_write(ADDR_CR, 16'hFFFF);
  endtask

  // Bytes held in the deep FIFO survive a switch to single-byte depth and
  // read out normally, while the full flag shows.
  task automatic test_depth_shrink();
    do_write(ADDR_LCR, 16'h00FF);
    do_receive(8'h11);
    do_receive(8'hEE);
    do_write(ADDR_LCR, 16'h0000);
    do_receive(8'h77);
    do_read(ADDR_FR);
    do_read(ADDR_DR);
    do_read(ADDR_DR);
  endtask

  // Unused operation, unaligned and unmapped offsets, read-only targets and
  // the ID pages at their reset values.
  task automatic test_odd_accesses();
    send_beat(beat_of(OP_UNUSED, 12'hFFF, 16'hFFFF, 8'hFF));
    do_write(ADDR_CR | 12'h001, 16'h0000);
    do_read(ADDR_CR | 12'h003);
    do_write(ADDR_RIS, 16'hFFFF);
    do_write(ADDR_RSR, 16'hFFFF);
    do_read(ADDR_RSR);
    do_read(ADDR_ICR);
    do_read(ADDR_DMACR + 12'h004);
    do_read({ID_PERIPH_PAGE, 4'h0});
    do_read({ID_CELL_PAGE, 4'hC});
  endtask

  // Registers that are merely stored keep only their own width.
  task automatic test_stored_registers();
    do_write(ADDR_ILPR, 16'hFFFF);
    do_write(ADDR_IBRD, 16'hFFFF);
    do_write(ADDR_FBRD, 16'hFFFF);
    do_write(ADDR_IFLS, 16'hFFFF);
    do_write(ADDR_DMACR, 16'hFFFF);
    do_read(ADDR_FBRD);
    do_read(ADDR_IFLS);
  endtask

  // Loads both ID registers and reads back all eight ID bytes.
  task automatic test_id_registers(logic [31:0] p, logic [31:0] c);
    wait_idle();
    write_id_register(CFG_PERIPH_ID, p);
    write_id_register(CFG_CELL_ID, c);
    for (int i = 0; i < 4; i++) begin
      do_read({ID_PERIPH_PAGE, 2'(i), 2'b00});
      do_read({ID_CELL_PAGE, 2'(i), 2'b00});
    end
  endtask

  function automatic logic [11:0] pick_register_addr();
    case ($urandom_range(13))
      0:       return ADDR_DR;
      1:       return ADDR_RSR;
      2:       return ADDR_FR;
      3:       return ADDR_ILPR;
      4:       return ADDR_IBRD;
      5:       return ADDR_FBRD;
      6:       return ADDR_LCR;
      7:       return ADDR_CR;
      8:       return ADDR_IFLS;
      9:       return ADDR_IMSC;
      10:      return ADDR_RIS;
      11:      return ADDR_MIS;
      12:      return ADDR_ICR;
      default: return ADDR_DMACR;
    endcase
  endfunction

  function automatic logic [11:0] pick_control_addr();
    case ($urandom_range(3))
      0:       return ADDR_LCR;
      1:       return ADDR_CR;
      2:       return ADDR_IMSC;
      default: return ADDR_ICR;
    endcase
  endfunction

  // Write beat with random content. CR writes mostly keep the UART
  // enabled and LCR writes mostly keep the deep FIFO on, so that traffic
  // keeps reaching the fill levels and the transmit path.
  function automatic in_item_t write_beat(logic [11:0] a);
    in_item_t it;
    it = beat_of(OP_WRITE, a, 16'($urandom), 8'($urandom));
    if (a == ADDR_CR && $urandom_range(9) < 8) it.write_data = it.write_data | 16'h0301;
    if (a == ADDR_LCR && $urandom_range(9) < 7) it.write_data[LCR_FEN_BIT] = 1'b1;
    return it;
  endfunction

  function automatic in_item_t random_beat(traffic_t mix);
    in_item_t it;
    int unsigned roll;
    it = beat_of(OP_READ, 12'($urandom), 16'($urandom), 8'($urandom));
    roll = $urandom_range(99);
    case (mix)
      MIX_FILL: begin
        if (roll < 75) it.operation = OP_RX;
        else if (roll < 84) it.address = ADDR_DR;
        else if (roll < 90) it.address = ADDR_FR;
        else it = write_beat(pick_control_addr());
      end
      MIX_DRAIN: begin
        if (roll < 55) it.address = ADDR_DR;
        else if (roll < 62) it.address = ADDR_FR;
        else if (roll < 66) it.address = ADDR_RIS;
        else if (roll < 70) it.address = ADDR_MIS;
        else if (roll < 85) it.operation = OP_RX;
        else it = write_beat(pick_control_addr());
      end
      default: begin
        if (roll < 25) begin
          it.operation = OP_RX;
        end else if (roll < 50) begin
          it.address = pick_register_addr();
        end else if (roll < 80) begin
          it = write_beat(pick_register_addr());
        end else if (roll < 88) begin
          // Entirely random beat, the unused operation included.
          it.operation = 2'($urandom);
        end else if (roll < 94) begin
          it.address = {($urandom_range(1) != 0) ? ID_PERIPH_PAGE : ID_CELL_PAGE,
                        2'($urandom), 2'b00};
        end else begin
          it.operation = ($urandom_range(1) != 0) ? OP_READ : OP_WRITE;
          it.address   = pick_register_addr() | 12'($urandom_range(3, 1));
        end
      end
    endcase
    return it;
  endfunction

  // One phase of random traffic under a given handshake pressure. Halfway
  // through, the sender stops until every response has come back.
  task automatic test_random_traffic(int unsigned n, int unsigned idle_pct,
                                     int unsigned stall);
    traffic_t    mix;
    int unsigned left;
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    mix  = MIX_ANY;
    left = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (left == 0) begin
        mix  = traffic_t'($urandom_range(2));
        left = $urandom_range(24, 4);
      end
      left--;
      if (i == n / 2) wait_idle();
      send_beat(random_beat(mix));
    end
    wait_idle();
  endtask

  initial begin
    req_if.valid = 1'b0;
    req_if.data  = '0;
    cfg_we       = 1'b0;
    cfg_index    = CFG_PERIPH_ID;
    cfg_data     = '0;
    rst          = 1'b1;
    reset_uart_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed checks run without idling on either side.
    test_receive_single();
    test_transmit_and_interrupts();
    test_disabled_paths();
    test_depth_shrink();
    test_odd_accesses();
    test_stored_registers();

    // Each pressure phase starts from its own pair of ID values, the
    // all-zero and all-one extremes among them.
    test_id_registers($urandom, $urandom);
    test_random_traffic(500, 0, 0);
    test_id_registers(32'h0000_0000, 32'h0000_0000);
    test_random_traffic(500, 71, 0);
    test_id_registers(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    test_random_traffic(500, 0, 71);
    test_id_registers($urandom, $urandom);
    test_random_traffic(500, 36, 36);

    wait_idle();
    repeat (8) @(posedge clk);
    if (pending_responses.size() != 0) begin
      $error("%0d responses never arrived", pending_responses.size());
      n_errors++;
    end

    $display("Checked %0d responses for %0d request beats: %0d bytes sent, %0d popped,",
             n_checked, n_beats, n_tx_bytes, n_popped);
    $display("%0d dropped at a full FIFO; four pressure mixes, ID values zero, ones, random.",
             n_dropped);
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/urf_pkg.sv
rtl/urf_ifs.sv
rtl/urf_rx_fifo.sv
rtl/urf_core.sv
rtl/uart_register_file_with_rx_fifo.sv
tb/tb_uart_register_file_with_rx_fifo.sv
